// File: rtl/spdc_pkg.sv
// Shared constants for the sampled PD controller: register map, reset values, field widths.
package spdc_pkg;

    localparam int DATA_WIDTH_DEF = 16;

    localparam int GAIN_W   = 16;
    localparam int LIMIT_W  = 15;
    localparam int PERIOD_W = 16;
    localparam int CMD_W    = 16;
    localparam int COUNT_W  = 32;
    localparam int PEAK_W   = 16;
    localparam int SUM_W    = 48;
    // squares are only formed for |error| below 2^SQ_IN_W; larger saturates the sum
    localparam int SQ_IN_W  = 24;

    localparam int APB_DW = 32;
    localparam int APB_AW = 5;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_KP_GAIN       = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_KD_GAIN       = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DRIVE_LIMIT   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DELAY_MODE    = 3'd4;

    localparam logic [GAIN_W-1:0]   KP_RESET     = 16'd2048;
    localparam logic [GAIN_W-1:0]   KD_RESET     = 16'd179;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 15'd12288;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd20;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [PEAK_W-1:0]  PEAK_MAX  = {PEAK_W{1'b1}};
    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};

    // result tdata: command, sample_taken, clipped, clip_count, error_peak, sum_sq_error
    localparam int RES_BITS = CMD_W + 2 + COUNT_W + PEAK_W + SUM_W;
    localparam int RES_TDATA_W = ((RES_BITS + 7) / 8) * 8;

endpackage

// File: rtl/sampled_pd_controller.sv
// Sampled PD controller top level: APB registers, product stage and state/result stage.
// Path: each result passes the product register, then the result register, before its
// transfer; a stalled output can hold it in either stage.
// Throughput: one transfer per cycle; s_axis_tready follows
// the output register, so a stalled result stalls input only once both stages are full.
// Reset (aresetn low, synchronous): registers return to defaults, phase, held and
// pending commands, clip count, peak and square sum clear, both stages empty.
module sampled_pd_controller #(
    parameter int DATA_WIDTH = spdc_pkg::DATA_WIDTH_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // APB configuration
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [spdc_pkg::APB_AW-1:0]             paddr,
    input  logic [spdc_pkg::APB_DW-1:0]             pwdata,
    output logic [spdc_pkg::APB_DW-1:0]             prdata,
    output logic                                    pready,
    // input stream
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // target, position, velocity (low to high), zero padded to bytes
    input  logic [((3*DATA_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
    // result stream
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // command, sample_taken, clipped, clip_count, error_peak, sum_sq_error (low to high)
    output logic [spdc_pkg::RES_TDATA_W-1:0]        m_axis_tdata
);

    localparam int ERR_W  = DATA_WIDTH + 1;
    localparam int PROP_W = DATA_WIDTH + 18;
    localparam int DER_W  = DATA_WIDTH + 17;
    localparam int SUMD_W = DATA_WIDTH + 19;
    localparam int EXT_W  = (ERR_W > spdc_pkg::SQ_IN_W + 1) ? ERR_W : spdc_pkg::SQ_IN_W + 1;
    localparam int PAD_W  = spdc_pkg::RES_TDATA_W - spdc_pkg::RES_BITS;

    // ---------------- configuration ----------------
    logic [spdc_pkg::GAIN_W-1:0]   kp_gain_reg, kd_gain_reg;
    logic [spdc_pkg::LIMIT_W-1:0]  drive_limit_reg;
    logic [spdc_pkg::PERIOD_W-1:0] sample_period_reg;
    logic                          delay_mode_reg;
    logic                          cfg_wr;
    logic [spdc_pkg::REG_IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[spdc_pkg::APB_AW-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_gain_reg       <= spdc_pkg::KP_RESET;
            kd_gain_reg       <= spdc_pkg::KD_RESET;
            drive_limit_reg   <= spdc_pkg::LIMIT_RESET;
            sample_period_reg <= spdc_pkg::PERIOD_RESET;
            delay_mode_reg    <= 1'b0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                spdc_pkg::REG_KP_GAIN:       kp_gain_reg <= pwdata[spdc_pkg::GAIN_W-1:0];
                spdc_pkg::REG_KD_GAIN:       kd_gain_reg <= pwdata[spdc_pkg::GAIN_W-1:0];
                spdc_pkg::REG_DRIVE_LIMIT:   drive_limit_reg <= pwdata[spdc_pkg::LIMIT_W-1:0];
                spdc_pkg::REG_SAMPLE_PERIOD: sample_period_reg <= pwdata[spdc_pkg::PERIOD_W-1:0];
                spdc_pkg::REG_DELAY_MODE:    delay_mode_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            spdc_pkg::REG_KP_GAIN:       prdata = spdc_pkg::APB_DW'(kp_gain_reg);
            spdc_pkg::REG_KD_GAIN:       prdata = spdc_pkg::APB_DW'(kd_gain_reg);
            spdc_pkg::REG_DRIVE_LIMIT:   prdata = spdc_pkg::APB_DW'(drive_limit_reg);
            spdc_pkg::REG_SAMPLE_PERIOD: prdata = spdc_pkg::APB_DW'(sample_period_reg);
            spdc_pkg::REG_DELAY_MODE:    prdata = spdc_pkg::APB_DW'(delay_mode_reg);
            default:                     prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    logic s1_valid_reg, m_valid_reg;
    logic out_free, s_accept, advance;

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || out_free;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign advance       = s1_valid_reg && out_free;
    assign m_axis_tvalid = m_valid_reg;

    // ---------------- stage 1: error, products, square ----------------
    logic signed [DATA_WIDTH-1:0] tgt_in, pos_in, vel_in;
    logic signed [ERR_W-1:0]      err;
    logic [ERR_W-1:0]             aerr;
    logic [EXT_W-1:0]             aerr_ext;
    logic [spdc_pkg::SQ_IN_W-1:0] aerr_sq_in;
    logic signed [PROP_W-1:0]     prop_next;
    logic signed [DER_W-1:0]      deriv_next;
    logic [spdc_pkg::PEAK_W-1:0]  peak_cand_next;
    logic                         sq_big_next;
    logic [spdc_pkg::SUM_W-1:0]   sq_next;

    logic signed [PROP_W-1:0]     prop_reg;
    logic signed [DER_W-1:0]      deriv_reg;
    logic [spdc_pkg::PEAK_W-1:0]  peak_cand_reg;
    logic                         sq_big_reg;
    logic [spdc_pkg::SUM_W-1:0]   sq_reg;

    assign tgt_in = s_axis_tdata[DATA_WIDTH-1:0];
    assign pos_in = s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
    assign vel_in = s_axis_tdata[3*DATA_WIDTH-1:2*DATA_WIDTH];

    always_comb begin
        err        = ERR_W'(tgt_in) - ERR_W'(pos_in);
        aerr       = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
        aerr_ext   = EXT_W'(aerr);
        aerr_sq_in = aerr_ext[spdc_pkg::SQ_IN_W-1:0];
        prop_next  = $signed({1'b0, kp_gain_reg}) * err;
        deriv_next = $signed({1'b0, kd_gain_reg}) * vel_in;
        // peak saturates at full scale of the 16-bit field
        peak_cand_next = (aerr_ext > EXT_W'(spdc_pkg::PEAK_MAX)) ? spdc_pkg::PEAK_MAX
                                                                 : aerr_ext[spdc_pkg::PEAK_W-1:0];
        sq_big_next = (aerr_ext >= (EXT_W'(1) << spdc_pkg::SQ_IN_W));
        sq_next     = spdc_pkg::SUM_W'(aerr_sq_in) * spdc_pkg::SUM_W'(aerr_sq_in);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            prop_reg      <= prop_next;
            deriv_reg     <= deriv_next;
            peak_cand_reg <= peak_cand_next;
            sq_big_reg    <= sq_big_next;
            sq_reg        <= sq_next;
        end
    end

    // ---------------- stage 2: controller state and result ----------------
    logic [spdc_pkg::PERIOD_W-1:0] phase_count_reg, phase_count_next;
    logic [spdc_pkg::CMD_W-1:0]    held_command_reg, held_command_next;
    logic [spdc_pkg::CMD_W-1:0]    pending_command_reg, pending_command_next;
    logic [spdc_pkg::COUNT_W-1:0]  clip_total_reg, clip_total_next;
    logic [spdc_pkg::PEAK_W-1:0]   peak_abs_error_reg, peak_abs_error_next;
    logic [spdc_pkg::SUM_W-1:0]    error_square_sum_reg, error_square_sum_next;

    logic signed [SUMD_W-1:0]      pd_sum, pd_round, lim_pos, lim_neg;
    logic [spdc_pkg::CMD_W-1:0]    new_cmd;
    logic [spdc_pkg::PERIOD_W:0]   phase_inc;
    logic                          taken, clip;
    logic                          taken_reg, clip_reg;

    always_comb begin
        taken    = (phase_count_reg == '0);
        pd_sum   = SUMD_W'(prop_reg) - SUMD_W'(deriv_reg);
        // round half up to Q3.12: floor((x + 128) / 256)
        pd_round = (pd_sum + SUMD_W'(128)) >>> 8;
        lim_pos  = $signed(SUMD_W'(drive_limit_reg));
        lim_neg  = -lim_pos;
        clip     = 1'b0;
        new_cmd  = pd_round[spdc_pkg::CMD_W-1:0];
        if (pd_round > lim_pos) begin
            new_cmd = lim_pos[spdc_pkg::CMD_W-1:0];
            clip    = taken;
        end else if (pd_round < lim_neg) begin
            new_cmd = lim_neg[spdc_pkg::CMD_W-1:0];
            clip    = taken;
        end

        held_command_next    = held_command_reg;
        pending_command_next = pending_command_reg;
        clip_total_next      = clip_total_reg;
        if (taken) begin
            if (delay_mode_reg) begin
                held_command_next    = pending_command_reg;
                pending_command_next = new_cmd;
            end else begin
                held_command_next = new_cmd;
            end
            if (clip && clip_total_reg != spdc_pkg::COUNT_MAX) begin
                clip_total_next = clip_total_reg + 1'b1;
            end
        end

        // a period of zero acts as one since the incremented phase always wraps
        phase_inc = {1'b0, phase_count_reg} + 1'b1;
        phase_count_next = (phase_inc >= {1'b0, sample_period_reg}) ? '0
                                                : phase_inc[spdc_pkg::PERIOD_W-1:0];

        peak_abs_error_next = (peak_cand_reg > peak_abs_error_reg) ? peak_cand_reg
                                                                   : peak_abs_error_reg;

        if (sq_big_reg || (sq_reg >= spdc_pkg::SUM_MAX - error_square_sum_reg)) begin
            error_square_sum_next = spdc_pkg::SUM_MAX;
        end else begin
            error_square_sum_next = error_square_sum_reg + sq_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg          <= 1'b0;
            phase_count_reg      <= '0;
            held_command_reg     <= '0;
            pending_command_reg  <= '0;
            clip_total_reg       <= '0;
            peak_abs_error_reg   <= '0;
            error_square_sum_reg <= '0;
        end else begin
            if (out_free) begin
                m_valid_reg <= s1_valid_reg;
            end
            if (advance) begin
                phase_count_reg      <= phase_count_next;
                held_command_reg     <= held_command_next;
                pending_command_reg  <= pending_command_next;
                clip_total_reg       <= clip_total_next;
                peak_abs_error_reg   <= peak_abs_error_next;
                error_square_sum_reg <= error_square_sum_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            taken_reg <= taken;
            clip_reg  <= clip;
        end
    end

    // state registers double as the result payload
    assign m_axis_tdata = {{PAD_W{1'b0}}, error_square_sum_reg, peak_abs_error_reg,
                           clip_total_reg, clip_reg, taken_reg, held_command_reg};

endmodule

// File: tb/pd_command_checker.sv
// Checker for the sampled PD controller: mirrors the register writes, checks register reads, predicts every result.
`timescale 1ns / 100ps
module pd_command_checker (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          psel,
    input  logic                                          penable,
    input  logic                                          pwrite,
    input  logic [spdc_pkg::APB_AW-1:0]                   paddr,
    input  logic [spdc_pkg::APB_DW-1:0]                   pwdata,
    input  logic [spdc_pkg::APB_DW-1:0]                   prdata,
    input  logic                                          pready,
    input  logic                                          s_axis_tvalid,
    input  logic                                          s_axis_tready,
    // target, position, velocity (low to high)
    input  logic [((3*spdc_pkg::DATA_WIDTH_DEF+7)/8)*8-1:0] s_axis_tdata,
    input  logic                                          m_axis_tvalid,
    input  logic                                          m_axis_tready,
    // command, sample_taken, clipped, clip_count, error_peak, sum_sq_error (low to high)
    input  logic [spdc_pkg::RES_TDATA_W-1:0]              m_axis_tdata,
    output int                                            pending,
    output int                                            mismatches
);

    localparam int CMD_W = spdc_pkg::CMD_W;

    // first member lands in the top bits, so this matches the result word from the bottom up
    typedef struct packed {
        logic [spdc_pkg::SUM_W-1:0]   sum_sq;
        logic [spdc_pkg::PEAK_W-1:0]  peak;
        logic [spdc_pkg::COUNT_W-1:0] clips;
        logic                         clipped;
        logic                         taken;
        logic [CMD_W-1:0]             command;
    } tick_result_t;

    logic [spdc_pkg::GAIN_W-1:0]   kp;
    logic [spdc_pkg::GAIN_W-1:0]   kd;
    logic [spdc_pkg::LIMIT_W-1:0]  limit;
    logic [spdc_pkg::PERIOD_W-1:0] period;
    logic                          delay_on;

    int unsigned                   phase;
    logic [CMD_W-1:0]              held;
    logic [CMD_W-1:0]              pending_cmd;
    logic [spdc_pkg::COUNT_W-1:0]  clip_total;
    logic [spdc_pkg::PEAK_W-1:0]   peak;
    logic [spdc_pkg::SUM_W-1:0]    sq_sum;

    tick_result_t        expected_ticks[$];

    function automatic tick_result_t step_controller(input logic [3*CMD_W-1:0] word);
        logic signed [CMD_W-1:0] tgt, pos, vel;
        longint       err, aerr, raw, lim, next_cmd, sq;
        int unsigned  nxt;
        tick_result_t r;
        tgt = word[CMD_W-1:0];
        pos = word[2*CMD_W-1:CMD_W];
        vel = word[3*CMD_W-1:2*CMD_W];
        err = longint'(tgt) - longint'(pos);
        aerr = (err < 0) ? -err : err;
        r.taken = 1'b0;
        r.clipped = 1'b0;
        if (phase == 0) begin
            // Q.20 product, round half up to Q3.12
            raw = (longint'(kp) * err - longint'(kd) * longint'(vel) + 128) >>> 8;
            lim = longint'(limit);
            next_cmd = raw;
            r.taken = 1'b1;
            if (raw > lim) begin
                next_cmd = lim;
                r.clipped = 1'b1;
            end else if (raw < -lim) begin
                next_cmd = -lim;
                r.clipped = 1'b1;
            end
            if (r.clipped && clip_total != spdc_pkg::COUNT_MAX)
                clip_total = clip_total + 1'b1;
            if (delay_on) begin
                held = pending_cmd;
                pending_cmd = next_cmd[CMD_W-1:0];
            end else begin
                held = next_cmd[CMD_W-1:0];
            end
        end
        // a period of zero wraps every tick, same as one
        nxt = phase + 1;
        phase = (nxt >= period) ? 0 : nxt;
        if (aerr > longint'(spdc_pkg::PEAK_MAX))
            aerr = longint'(spdc_pkg::PEAK_MAX);
        if (aerr > longint'(peak))
            peak = aerr[spdc_pkg::PEAK_W-1:0];
        sq = aerr * aerr;
        if (longint'(spdc_pkg::SUM_MAX) - longint'(sq_sum) <= sq)
            sq_sum = spdc_pkg::SUM_MAX;
        else
            sq_sum = sq_sum + sq[spdc_pkg::SUM_W-1:0];
        r.command = held;
        r.clips = clip_total;
        r.peak = peak;
        r.sum_sq = sq_sum;
        return r;
    endfunction

    function automatic logic [spdc_pkg::APB_DW-1:0] reg_value(
        input logic [spdc_pkg::REG_IDX_W-1:0] idx);
        case (idx)
            spdc_pkg::REG_KP_GAIN:       return spdc_pkg::APB_DW'(kp);
            spdc_pkg::REG_KD_GAIN:       return spdc_pkg::APB_DW'(kd);
            spdc_pkg::REG_DRIVE_LIMIT:   return spdc_pkg::APB_DW'(limit);
            spdc_pkg::REG_SAMPLE_PERIOD: return spdc_pkg::APB_DW'(period);
            spdc_pkg::REG_DELAY_MODE:    return spdc_pkg::APB_DW'(delay_on);
            default:                     return '0;
        endcase
    endfunction

    function automatic int field_differs(input string name, input logic [63:0] want,
                                         input logic [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge aclk) begin
        tick_result_t got, want;
        int           miss;
        miss = 0;
        if (!aresetn) begin
            kp = spdc_pkg::KP_RESET;
            kd = spdc_pkg::KD_RESET;
            limit = spdc_pkg::LIMIT_RESET;
            period = spdc_pkg::PERIOD_RESET;
            delay_on = 1'b0;
            phase = 0;
            held = '0;
            pending_cmd = '0;
            clip_total = '0;
            peak = '0;
            sq_sum = '0;
            expected_ticks.delete();
            pending <= 0;
            mismatches <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[spdc_pkg::RES_BITS-1:0];
                if (expected_ticks.size() == 0) begin
                    $error("result transfer with no expected result waiting");
                    miss++;
                end else begin
                    want = expected_ticks.pop_front();
                    miss += field_differs("command", 64'(want.command), 64'(got.command));
                    miss += field_differs("sample_taken", 64'(want.taken), 64'(got.taken));
                    miss += field_differs("clipped", 64'(want.clipped), 64'(got.clipped));
                    miss += field_differs("clip_count", 64'(want.clips), 64'(got.clips));
                    miss += field_differs("error_peak", 64'(want.peak), 64'(got.peak));
                    miss += field_differs("sum_sq_error", 64'(want.sum_sq), 64'(got.sum_sq));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_ticks.push_back(step_controller(s_axis_tdata[3*CMD_W-1:0]));
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (paddr[spdc_pkg::APB_AW-1:2])
                        spdc_pkg::REG_KP_GAIN:       kp = pwdata[spdc_pkg::GAIN_W-1:0];
                        spdc_pkg::REG_KD_GAIN:       kd = pwdata[spdc_pkg::GAIN_W-1:0];
                        spdc_pkg::REG_DRIVE_LIMIT:   limit = pwdata[spdc_pkg::LIMIT_W-1:0];
                        spdc_pkg::REG_SAMPLE_PERIOD: period = pwdata[spdc_pkg::PERIOD_W-1:0];
                        spdc_pkg::REG_DELAY_MODE:    delay_on = pwdata[0];
                        default: ;
                    endcase
                end else begin
                    miss += field_differs("prdata",
                                          64'(reg_value(paddr[spdc_pkg::APB_AW-1:2])),
                                          64'(prdata));
                end
            end
            pending <= expected_ticks.size();
            mismatches <= mismatches + miss;
        end
    end

endmodule

// File: tb/tb_sampled_pd_controller.sv
// Testbench top for the sampled PD controller: clock, reset, register setup, tick stimulus, verdict.
`timescale 1ns / 100ps
module tb_sampled_pd_controller;

    localparam int DW = spdc_pkg::DATA_WIDTH_DEF;
    localparam int IN_W = ((3*DW+7)/8)*8;
    localparam int APB_DW = spdc_pkg::APB_DW;
    localparam int REG_IDX_W = spdc_pkg::REG_IDX_W;
    localparam logic [REG_IDX_W-1:0] REG_SPARE = 3'd5;  // decodes to no register
    localparam int RANDOM_PHASES = 8;
    localparam int TICKS_PER_PHASE = 125;
    localparam int SAT_TICKS = 40;  // max-error ticks, every update clips

    typedef enum {SHAPE_ANY, SHAPE_NEAR, SHAPE_WIDE, SHAPE_EDGE} tick_shape_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [spdc_pkg::APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0]   pwdata = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [IN_W-1:0]     s_axis_tdata = '0;  // target, position, velocity (low to high)
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // command, sample_taken, clipped, clip_count, error_peak, sum_sq_error (low to high)
    logic [spdc_pkg::RES_TDATA_W-1:0] m_axis_tdata;

    int                  send_idle_pct = 0;
    int                  stall_pct = 0;
    int                  pending;
    int                  mismatches;

    sampled_pd_controller #(.DATA_WIDTH(DW)) u_dut (.*);

    pd_command_checker u_checker (.*);

    always #5 aclk = ~aclk;

    always @(posedge aclk)
        m_axis_tready <= ($urandom_range(99) >= stall_pct);

    task automatic apb_access(input logic wr, input logic [REG_IDX_W-1:0] idx,
                              input logic [APB_DW-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // stop sending and wait until every expected result has been transferred
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_regs(input logic [APB_DW-1:0] kp, kd, lim, per, dly);
        logic [REG_IDX_W-1:0] idx [5];
        logic [APB_DW-1:0]    val [5];
        idx = '{spdc_pkg::REG_KP_GAIN, spdc_pkg::REG_KD_GAIN, spdc_pkg::REG_DRIVE_LIMIT,
                spdc_pkg::REG_SAMPLE_PERIOD, spdc_pkg::REG_DELAY_MODE};
        val = '{kp, kd, lim, per, dly};
        wait_for_results();
        foreach (idx[k]) apb_access(1'b1, idx[k], val[k]);
        foreach (idx[k]) apb_access(1'b0, idx[k], '0);
    endtask

    task automatic send_tick(input logic [DW-1:0] tgt, pos, vel);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {vel, pos, tgt};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    function automatic logic [DW-1:0] extreme_value();
        case ($urandom_range(3))
            0:       return {1'b1, {(DW-1){1'b0}}};
            1:       return {1'b0, {(DW-1){1'b1}}};
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    task automatic random_tick();
        logic [DW-1:0] t, p, v;
        tick_shape_t   shape;
        shape = tick_shape_t'($urandom_range(3));
        t = DW'($urandom);
        case (shape)
            SHAPE_ANY: begin
                p = DW'($urandom);
                v = DW'($urandom);
            end
            SHAPE_NEAR: begin
                p = t + DW'($urandom_range(1023)) - DW'(512);
                v = DW'($urandom_range(1023)) - DW'(512);
            end
            SHAPE_WIDE: begin
                p = t + DW'($urandom_range(8191)) - DW'(4096);
                v = DW'($urandom_range(8191)) - DW'(4096);
            end
            default: begin
                t = extreme_value();
                p = extreme_value();
                v = extreme_value();
            end
        endcase
        send_tick(t, p, v);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // defaults after reset; small errors first so the peak climbs in steps
        send_tick(16'sd100, 16'sd0, 16'sd0);
        send_tick(16'sd400, 16'sd100, 16'sd50);
        send_tick(-16'sd2000, 16'sd0, 16'sd0);

        // upper bits of the write data are ignored; period zero updates every tick
        set_regs('1, '1, '1, '0, '0);
        apb_access(1'b1, REG_SPARE, $urandom);
        send_tick(16'h7FFF, 16'h8000, 16'h8000);
        send_tick(16'h8000, 16'h7FFF, 16'h7FFF);
        send_tick(16'h0000, 16'h0000, 16'h0000);
        send_tick(16'h7FFF, 16'h7FFF, 16'h8000);
        send_tick(16'h8000, 16'h8000, 16'h7FFF);

        // rounding of halves in both directions
        set_regs(1, 0, 32767, 1, 0);
        send_tick(16'sd128, 16'sd0, 16'sd0);
        send_tick(16'sd127, 16'sd0, 16'sd0);
        send_tick(-16'sd128, 16'sd0, 16'sd0);
        send_tick(-16'sd129, 16'sd0, 16'sd0);
        send_tick(16'sd0, 16'sd384, 16'sd0);

        // exactly at the limit is not a clip; delayed command
        set_regs(256, 0, 1000, 1, 1);
        send_tick(16'sd1000, 16'sd0, 16'sd0);
        send_tick(16'sd1001, 16'sd0, 16'sd0);
        send_tick(-16'sd1000, 16'sd0, 16'sd0);
        send_tick(-16'sd1001, 16'sd0, 16'sd0);
        send_tick(16'sd0, 16'sd0, 16'sd0);

        // zero limit, period two, delayed
        set_regs(APB_DW'(spdc_pkg::KP_RESET), APB_DW'(spdc_pkg::KD_RESET), 0, 2, 1);
        send_tick(16'sd5, 16'sd0, 16'sd0);
        send_tick(16'sd0, 16'sd0, 16'sd0);
        send_tick(-16'sd5, 16'sd0, 16'sd7);
        send_tick(16'sd0, 16'sd0, 16'sd0);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: set_regs(APB_DW'(spdc_pkg::KP_RESET), APB_DW'(spdc_pkg::KD_RESET),
                            APB_DW'(spdc_pkg::LIMIT_RESET), APB_DW'(spdc_pkg::PERIOD_RESET), 0);
                1: set_regs($urandom_range(4096), $urandom_range(1024),
                            $urandom_range(32767), 1, 1);
                2: set_regs(65535, 0, 32767, 65535, 0);
                // period drops well below the running phase
                3: set_regs($urandom, $urandom, 0, 3, 1);
                4: set_regs(0, 65535, $urandom_range(32767), 0, 0);
                5: set_regs($urandom_range(8192), $urandom_range(4096), $urandom_range(32767),
                            $urandom_range(8, 1), $urandom_range(1));
                6: set_regs($urandom_range(512), $urandom_range(512), 32767, 1, 0);
                default: set_regs($urandom_range(2048), $urandom_range(2048),
                                  $urandom_range(32767), 5, 1);
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct <= 0;  end
                1: begin send_idle_pct = 72; stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  stall_pct <= 72; end
                default: begin send_idle_pct = 10; stall_pct <= 10; end
            endcase
            for (int i = 0; i < TICKS_PER_PHASE; i++) begin
                if (ph == 1 && i == TICKS_PER_PHASE / 2)
                    wait_for_results();
                random_tick();
            end
        end

        // run at maximum error with a small limit: every update clips
        set_regs(65535, 0, 100, 1, 0);
        send_idle_pct = 0;
        stall_pct <= 0;
        for (int i = 0; i < SAT_TICKS; i++)
            send_tick(16'h7FFF, 16'h8000, DW'($urandom));
        send_idle_pct = 10;
        stall_pct <= 72;
        for (int i = 0; i < 20; i++)
            random_tick();

        wait_for_results();
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
